// ===== hw/rtl/pulse_heart_rate_detector_assert.svh =====
// Assertion macros for the pulse heart rate detector.
`ifndef PULSE_HEART_RATE_DETECTOR_ASSERT_SVH
`define PULSE_HEART_RATE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PHR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PHR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/phr_pkg.sv =====
// Shared types and constants of the pulse heart rate detector.
`timescale 1ns / 1ps
`default_nettype none

package phr_pkg;

    localparam int ALU_W      = 17;
    localparam int IBI_W      = 16;
    localparam int RATE_W     = 10;
    localparam int PERIOD_W   = 8;
    localparam int TICK_W     = 16;
    localparam int FILL_W     = 8;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPM_HIGH = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPM_LOW  = 4'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd20;
    localparam logic [RATE_W-1:0]   BPM_HIGH_RST = 10'd200;
    localparam logic [RATE_W-1:0]   BPM_LOW_RST  = 10'd30;

    localparam logic [IBI_W-1:0] IBI_MIN   = 16'd250;
    localparam logic [IBI_W-1:0] BPM_NUMER = 16'd60000;

    localparam logic [CNT_W-1:0] MUL_LAST = 4'd7;
    localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic               enable;
        logic [PERIOD_W-1:0] period;
        logic [RATE_W-1:0]  bpm_high;
        logic [RATE_W-1:0]  bpm_low;
    } cfg_t;

    typedef struct packed {
        logic             beat_valid;
        logic [RATE_W-1:0] rate;
        logic [IBI_W-1:0] ibi;
        logic             level;
    } res_t;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/phr_alu.sv =====
// Shared adder-subtractor used by the multiply and divide steps.
`timescale 1ns / 1ps
`default_nettype none

module phr_alu (
    input  phr_pkg::alu_req_t      req,
    output logic [phr_pkg::ALU_W:0] res
);
    import phr_pkg::*;

    // The top bit is the carry of an add or the borrow of a subtract.
    always_comb begin
        unique case (req.op)
            ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
            default: res = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/phr_seq.sv =====
// Detector state and the sequencer that drives the shared arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

module phr_seq #(
    parameter int WINDOW_SIZE = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  phr_pkg::cfg_t          cfg,
    input  logic                   start,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   out_free,
    output logic                   idle,
    output logic                   done,
    output phr_pkg::res_t          res,
    output logic [SAMPLE_BITS-1:0] threshold
);
    import phr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_WIN  = 4'd1;
    localparam logic [3:0] ST_MID  = 4'd2;
    localparam logic [3:0] ST_LVL  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_LIM  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_SIZE);

    logic [3:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [SAMPLE_BITS-1:0] last_reg, last_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [SAMPLE_BITS-1:0] mid_reg, mid_next;
    logic [SAMPLE_BITS-1:0] half_reg, half_next;
    logic                   level_reg, level_next;
    logic                   parity_reg, parity_next;
    logic [TICK_W-1:0]      first_reg, first_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [IBI_W-1:0]       acc_reg, acc_next;
    logic [IBI_W-1:0]       mcand_reg, mcand_next;
    logic [PERIOD_W-1:0]    mult_reg, mult_next;
    logic [IBI_W-1:0]       ibi_reg, ibi_next;
    logic [IBI_W-1:0]       rem_reg, rem_next;
    logic [IBI_W-1:0]       dvd_reg, dvd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   bv_reg, bv_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [IBI_W-1:0]       rib_reg, rib_next;

    alu_req_t               alu_req;
    logic [ALU_W:0]         alu_res;

    logic signed [SAMPLE_BITS:0] rise;
    logic                   taken;
    logic [FILL_W-1:0]      fill_inc;
    logic [SAMPLE_BITS:0]   mm_sum;
    logic [SAMPLE_BITS-1:0] mm_span;
    logic                   lvl_now;
    logic [RATE_W-1:0]      quo;

    phr_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign rise     = $signed({1'b0, smp_reg}) - $signed({1'b0, last_reg});
    assign taken    = rise < $signed({1'b0, half_reg});
    assign fill_inc = fill_reg + 1'b1;
    assign mm_sum   = {1'b0, max_reg} + {1'b0, min_reg};
    assign mm_span  = max_reg - min_reg;
    assign lvl_now  = smp_reg > mid_reg;
    assign quo      = dvd_reg[RATE_W-1:0];

    // The divide step feeds the shifted remainder; every other use is a shift-add.
    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {rem_reg, dvd_reg[IBI_W-1]};
            alu_req.b  = {1'b0, ibi_reg};
        end else begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {1'b0, acc_reg};
            alu_req.b  = {1'b0, mcand_reg};
        end
    end

    always_comb begin
        state_next  = state_reg;
        last_next   = last_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        fill_next   = fill_reg;
        mid_next    = mid_reg;
        half_next   = half_reg;
        level_next  = level_reg;
        parity_next = parity_reg;
        first_next  = first_reg;
        tick_next   = tick_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mult_next   = mult_reg;
        ibi_next    = ibi_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        cnt_next    = cnt_reg;
        bv_next     = bv_reg;
        rate_next   = rate_reg;
        rib_next    = rib_reg;
        done        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    bv_next    = 1'b0;
                    rate_next  = '0;
                    rib_next   = '0;
                    state_next = cfg.enable ? ST_WIN : ST_FIN;
                end
            end
            ST_WIN: begin
                last_next = smp_reg;
                if (taken) begin
                    if (smp_reg > max_reg) begin
                        max_next = smp_reg;
                    end
                    if (smp_reg < min_reg) begin
                        min_next = smp_reg;
                    end
                    if (fill_inc >= FILL_LAST) begin
                        fill_next = '0;
                    end else begin
                        fill_next = fill_inc;
                    end
                end
                state_next = (taken && (fill_inc >= FILL_LAST)) ? ST_MID : ST_LVL;
            end
            ST_MID: begin
                mid_next   = mm_sum[SAMPLE_BITS:1];
                half_next  = {1'b0, mm_span[SAMPLE_BITS-1:1]};
                max_next   = '0;
                min_next   = '1;
                state_next = ST_LVL;
            end
            ST_LVL: begin
                level_next = lvl_now;
                tick_next  = tick_reg + 1'b1;
                state_next = ST_FIN;
                if (!level_reg && lvl_now) begin
                    parity_next = !parity_reg;
                    if (!parity_reg) begin
                        first_next = tick_reg;
                    end else begin
                        // Second beat of a pair: interval = ticks times period.
                        tick_next  = TICK_W'(1);
                        acc_next   = '0;
                        mcand_next = tick_reg - first_reg;
                        mult_next  = cfg.period;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mult_reg[0]) begin
                    acc_next = alu_res[IBI_W-1:0];
                end
                mcand_next = {mcand_reg[IBI_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[PERIOD_W-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (acc_reg > IBI_MIN) begin
                    ibi_next   = acc_reg;
                    rem_next   = '0;
                    dvd_next   = BPM_NUMER;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit a cycle.
                if (!alu_res[ALU_W]) begin
                    rem_next = alu_res[IBI_W-1:0];
                    dvd_next = {dvd_reg[IBI_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[IBI_W-2:0], dvd_reg[IBI_W-1]};
                    dvd_next = {dvd_reg[IBI_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_LIM;
                end
            end
            ST_LIM: begin
                bv_next    = 1'b1;
                rib_next   = ibi_reg;
                rate_next  = ((quo > cfg.bpm_high) || (quo < cfg.bpm_low)) ? '0 : quo;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            last_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= '1;
            fill_reg   <= '0;
            mid_reg    <= '0;
            half_reg   <= '0;
            level_reg  <= 1'b0;
            parity_reg <= 1'b0;
            first_reg  <= '0;
            tick_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            fill_reg   <= fill_next;
            mid_reg    <= mid_next;
            half_reg   <= half_next;
            level_reg  <= level_next;
            parity_reg <= parity_next;
            first_reg  <= first_next;
            tick_reg   <= tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && (state_reg == ST_IDLE)) begin
            smp_reg <= sample;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        ibi_reg   <= ibi_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        cnt_reg   <= cnt_next;
        bv_reg    <= bv_next;
        rate_reg  <= rate_next;
        rib_reg   <= rib_next;
    end

    assign idle           = (state_reg == ST_IDLE);
    assign res.beat_valid = bv_reg;
    assign res.rate       = rate_reg;
    assign res.ibi        = rib_reg;
    assign res.level      = level_reg;
    assign threshold      = mid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pulse_heart_rate_detector.sv =====
// Top level of the pulse heart rate detector: ports, configuration and result register.
//
//  Channel   Direction  Handshake            Word
//  s_        in         s_valid / s_ready    s_adc_sample
//  m_        out        m_valid / m_ready    beat flag, rate, interval, level, threshold
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A sample goes from accept to the final step if the detector is disabled; enabled, it
// passes the window, midpoint (on a full window) and level steps. A closing beat pair
// adds the multiply and check steps, and one above 250 ms the divide and limit steps.
// The 8 shift-add interval multiply steps and the 16 restoring divide steps go through
// one shared adder-subtractor. Reset is synchronous and active low; it loads the
// configuration defaults and clears the detector state. A stalled result register holds
// the sequencer in its final step only while a finished word waits; no sample is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_heart_rate_detector_assert.svh"

module pulse_heart_rate_detector #(
    parameter int WINDOW_SIZE = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [SAMPLE_BITS-1:0]          s_adc_sample,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_beat_valid,
    output logic [phr_pkg::RATE_W-1:0]      m_heart_rate,
    output logic [phr_pkg::IBI_W-1:0]       m_beat_interval_ms,
    output logic                            m_above_threshold,
    output logic [SAMPLE_BITS-1:0]          m_threshold_level,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [phr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [phr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import phr_pkg::*;

    cfg_t                   cfg_reg;
    logic                   seq_idle;
    logic                   seq_done;
    logic                   out_free;
    res_t                   seq_res;
    logic [SAMPLE_BITS-1:0] seq_thr;

    logic                   m_valid_reg;
    res_t                   out_res_reg;
    logic [SAMPLE_BITS-1:0] out_thr_reg;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable   <= 1'b0;
            cfg_reg.period   <= PERIOD_RST;
            cfg_reg.bpm_high <= BPM_HIGH_RST;
            cfg_reg.bpm_low  <= BPM_LOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENABLE:   cfg_reg.enable   <= cfg_data[0];
                CFG_PERIOD:   cfg_reg.period   <= cfg_data[PERIOD_W-1:0];
                CFG_BPM_HIGH: cfg_reg.bpm_high <= cfg_data[RATE_W-1:0];
                CFG_BPM_LOW:  cfg_reg.bpm_low  <= cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer owns all detector state and runs one sample at a time.
    phr_seq #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (s_valid && s_ready),
        .sample    (s_adc_sample),
        .out_free  (out_free),
        .idle      (seq_idle),
        .done      (seq_done),
        .res       (seq_res),
        .threshold (seq_thr)
    );

    assign s_ready  = seq_idle;

    // The result register frees up in the same cycle its word is taken.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_done) begin
            out_res_reg <= seq_res;
            out_thr_reg <= seq_thr;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_beat_valid       = out_res_reg.beat_valid;
    assign m_heart_rate       = out_res_reg.rate;
    assign m_beat_interval_ms = out_res_reg.ibi;
    assign m_above_threshold  = out_res_reg.level;
    assign m_threshold_level  = out_thr_reg;

    // A finished word never overwrites one that is still waiting.
    `PHR_ASSERT_IMP(a_done_slot_free, aclk, aresetn, seq_done,
                    (!m_valid_reg || m_ready), "result overwritten")
    // Once a sample is taken the block is not ready in the cycle after.
    `PHR_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready),
                    !s_ready, "ready after accept")
    // A reported beat always carries an interval above the minimum.
    `PHR_ASSERT_IMP(a_beat_interval, aclk, aresetn, (m_valid && m_beat_valid),
                    (m_beat_interval_ms > IBI_MIN), "short interval reported")
    // Without a beat the rate and interval fields read zero.
    `PHR_ASSERT_IMP(a_no_beat_zero, aclk, aresetn, (m_valid && !m_beat_valid),
                    ((m_heart_rate == '0) && (m_beat_interval_ms == '0)), "stale beat fields")

endmodule

`default_nettype wire
